// ----- design/pinhole_rational_distortion_project_assert.svh -----
// Assertion macros shared by the pinhole projection design
`ifndef PINHOLE_RATIONAL_DISTORTION_PROJECT_ASSERT_SVH
`define PINHOLE_RATIONAL_DISTORTION_PROJECT_ASSERT_SVH
`ifndef SYNTHESIS
`define PRD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define PRD_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define PRD_ASSERT(lbl, clk, rst_n, prop)
`define PRD_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- design/pinrd_pkg.sv -----
// Shared types and constants for the pinhole projection pipeline
package pinrd_pkg;
	localparam int CFG_IW = 4;
	localparam int NQW = 26;
	localparam int QQW = 35;
	localparam logic signed [23:0] PIX_OFF = -24'sd256;

	typedef enum logic [CFG_IW-1:0] {
		REG_FOCAL_X = 4'd0,
		REG_FOCAL_Y = 4'd1,
		REG_CENTER_X = 4'd2,
		REG_CENTER_Y = 4'd3,
		REG_K1_K2 = 4'd4,
		REG_P1_P2 = 4'd5,
		REG_K3_K4 = 4'd6,
		REG_K5_K6 = 4'd7
	} cfg_reg_t;

	typedef struct packed {
		logic valid;
		logic view;
	} ctl_t;

	typedef struct packed {
		logic signed [23:0] k1;
		logic signed [23:0] k2;
		logic signed [23:0] k3;
		logic signed [23:0] k4;
		logic signed [23:0] k5;
		logic signed [23:0] k6;
		logic signed [23:0] p1;
		logic signed [23:0] p2;
	} coef_t;
endpackage

// ----- design/pinhole_rational_distortion_project.sv -----
// Top level: configuration registers, projection pipeline and output skid stage
//
//  channel   | handshake                | payload
//  ----------+--------------------------+--------------------------------
//  point     | point_valid/point_stall  | point_x, point_y, point_z
//  pixel     | pixel_valid/pixel_stall  | in_view, pixel_u, pixel_v
//  cfg       | cfg_valid/cfg_ready      | cfg_index, cfg_data
//
// One item per cycle while point_stall is low; the path from accept to pixel_valid runs
// through the two radix-2 divider chains (27 and 36 stages) plus scaling stages.
// arst_n clears valid bits, also skid and output valid; registers return to defaults.
// A stalled result parks in a one-entry skid; point_stall rises only while it is full.
module pinhole_rational_distortion_project #(
	parameter int IMAGE_WIDTH = 1024,
	parameter int IMAGE_HEIGHT = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pinrd_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [47:0]                   cfg_data,
	input  logic                          point_valid,
	output logic                          point_stall,
	input  logic signed [31:0]            point_x,
	input  logic signed [31:0]            point_y,
	input  logic signed [31:0]            point_z,
	output logic                          pixel_valid,
	input  logic                          pixel_stall,
	output logic                          in_view,
	output logic signed [23:0]            pixel_u,
	output logic signed [23:0]            pixel_v
);
	import pinrd_pkg::*;

	`include "pinhole_rational_distortion_project_assert.svh"

	logic [23:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
	logic [47:0] k12_q, p12_q, k34_q, k56_q;
	coef_t       coef;
	logic        en;
	ctl_t        pc, pe;
	logic signed [26:0] nx, ny;
	logic signed [23:0] eu, ev;
	logic        out_v_q, out_view_q;
	logic signed [23:0] out_u_q, out_pv_q;
	logic        skid_v_q, skid_view_q;
	logic signed [23:0] skid_u_q, skid_pv_q;
	logic        out_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q <= 24'd256;
			focal_y_q <= 24'd256;
			center_x_q <= '0;
			center_y_q <= '0;
			k12_q <= '0;
			p12_q <= '0;
			k34_q <= '0;
			k56_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_FOCAL_X: focal_x_q <= cfg_data[23:0];
				REG_FOCAL_Y: focal_y_q <= cfg_data[23:0];
				REG_CENTER_X: center_x_q <= cfg_data[23:0];
				REG_CENTER_Y: center_y_q <= cfg_data[23:0];
				REG_K1_K2: k12_q <= cfg_data;
				REG_P1_P2: p12_q <= cfg_data;
				REG_K3_K4: k34_q <= cfg_data;
				REG_K5_K6: k56_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		coef.k1 = k12_q[47:24];
		coef.k2 = k12_q[23:0];
		coef.p1 = p12_q[47:24];
		coef.p2 = p12_q[23:0];
		coef.k3 = k34_q[47:24];
		coef.k4 = k34_q[23:0];
		coef.k5 = k56_q[47:24];
		coef.k6 = k56_q[23:0];
	end

	assign en = !skid_v_q;
	assign point_stall = skid_v_q;

	pinrd_proj #(.IMAGE_WIDTH(IMAGE_WIDTH), .IMAGE_HEIGHT(IMAGE_HEIGHT)) u_proj (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(point_valid),
		.px(point_x), .py(point_y), .pz(point_z),
		.fx(focal_x_q), .fy(focal_y_q), .cx(center_x_q), .cy(center_y_q),
		.ctl_out(pc), .nx(nx), .ny(ny));

	pinrd_dist u_dist (
		.clk(clk), .arst_n(arst_n), .en(en), .ctl_in(pc), .x(nx), .y(ny), .coef(coef),
		.fx(focal_x_q), .fy(focal_y_q), .cx(center_x_q), .cy(center_y_q),
		.ctl_out(pe), .pu(eu), .pv(ev));

	assign out_free = !out_v_q || !pixel_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= skid_v_q || pe.valid;
			skid_v_q <= 1'b0;
		end else if (en && pe.valid) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q) begin
				out_view_q <= skid_view_q;
				out_u_q <= skid_u_q;
				out_pv_q <= skid_pv_q;
			end else begin
				out_view_q <= pe.view;
				out_u_q <= eu;
				out_pv_q <= ev;
			end
		end else if (en) begin
			skid_view_q <= pe.view;
			skid_u_q <= eu;
			skid_pv_q <= ev;
		end
	end

	assign pixel_valid = out_v_q;
	assign in_view = out_view_q;
	assign pixel_u = out_u_q;
	assign pixel_v = out_pv_q;

	`PRD_ASSERT(a_skid_needs_out, clk, arst_n, skid_v_q |-> out_v_q)
	`PRD_ASSERT(a_skid_empty_when_free, clk, arst_n, !out_v_q |=> !skid_v_q)
	`PRD_ASSERT(a_skid_drains, clk, arst_n, skid_v_q && !pixel_stall |=> out_v_q && !skid_v_q)
	`PRD_NEVER(a_off_view_value, clk, arst_n, out_v_q && !out_view_q && (out_u_q != PIX_OFF || out_pv_q != PIX_OFF))
endmodule

// ----- design/pinrd_div.sv -----
// Pipelined signed divider, one quotient bit per stage, truncating, magnitude clamped
module pinrd_div #(
	parameter int DW = 57,
	parameter int VW = 32,
	parameter int QW = 26
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [DW-1:0] num,
	input  logic signed [VW-1:0] den,
	output logic signed [QW:0]   quo,
	output logic                 ovf
);
	localparam int CW = ((DW > VW + QW) ? DW : VW + QW) + 1;

	logic [CW-1:0] rem_s [0:QW];
	logic [VW-1:0] dvs_s [0:QW];
	logic [QW-1:0] quo_s [0:QW];
	logic          neg_s [0:QW];
	logic          ovf_s [0:QW];
	logic [CW-1:0] shf   [1:QW];
	logic          ge    [1:QW];
	logic [DW-1:0] mag_n;
	logic [VW-1:0] mag_d;
	logic [QW-1:0] mag_q;

	always_comb begin
		mag_n = num[DW-1] ? DW'(-num) : DW'(num);
		mag_d = den[VW-1] ? VW'(-den) : VW'(den);
		for (int i = 1; i <= QW; i++) begin
			shf[i] = CW'(dvs_s[i-1]) << (QW - i);
			ge[i] = rem_s[i-1] >= shf[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= CW'(mag_n);
			dvs_s[0] <= mag_d;
			quo_s[0] <= '0;
			neg_s[0] <= num[DW-1] ^ den[VW-1];
			ovf_s[0] <= CW'(mag_n) >= (CW'(mag_d) << QW);
			for (int i = 1; i <= QW; i++) begin
				rem_s[i] <= ge[i] ? rem_s[i-1] - shf[i] : rem_s[i-1];
				quo_s[i] <= quo_s[i-1] | (QW'(ge[i]) << (QW - i));
				dvs_s[i] <= dvs_s[i-1];
				neg_s[i] <= neg_s[i-1];
				ovf_s[i] <= ovf_s[i-1];
			end
		end
	end

	always_comb begin
		mag_q = ovf_s[QW] ? '1 : quo_s[QW];
		quo = neg_s[QW] ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
		ovf = ovf_s[QW];
	end
endmodule

// ----- design/pinrd_proj.sv -----
// Front end: undistorted projection, view test and normalized coordinates
module pinrd_proj #(
	parameter int IMAGE_WIDTH = 1024,
	parameter int IMAGE_HEIGHT = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic signed [31:0]  px,
	input  logic signed [31:0]  py,
	input  logic signed [31:0]  pz,
	input  logic [23:0]         fx,
	input  logic [23:0]         fy,
	input  logic [23:0]         cx,
	input  logic [23:0]         cy,
	output pinrd_pkg::ctl_t     ctl_out,
	output logic signed [26:0]  nx,
	output logic signed [26:0]  ny
);
	import pinrd_pkg::*;

	localparam int DL = NQW + 1;
	localparam logic signed [28:0] U_MAX = 29'(IMAGE_WIDTH * 256);
	localparam logic signed [28:0] V_MAX = 29'(IMAGE_HEIGHT * 256);

	logic               v_s1;
	logic               zero_s1;
	logic signed [31:0] px_s1, py_s1, pz_s1;
	logic signed [56:0] pu_s1, pv_s1;
	logic               vd_q [0:DL-1];
	logic               zd_q [0:DL-1];
	logic signed [55:0] xn, yn;
	logic signed [NQW:0] du, dv, xq, yq;
	logic               ovf_u, ovf_v, ovf_x, ovf_y;
	logic signed [28:0] u, v;
	logic               view;
	ctl_t               ctl_s3;
	logic signed [26:0] x_s3, y_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int i = 0; i < DL; i++) vd_q[i] <= 1'b0;
			ctl_s3 <= '0;
		end else if (en) begin
			v_s1 <= in_valid;
			vd_q[0] <= v_s1;
			for (int i = 1; i < DL; i++) vd_q[i] <= vd_q[i-1];
			ctl_s3.valid <= vd_q[DL-1];
			ctl_s3.view <= view;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= px;
			py_s1 <= py;
			pz_s1 <= pz;
			zero_s1 <= (pz == '0);
			pu_s1 <= $signed({1'b0, fx}) * px;
			pv_s1 <= $signed({1'b0, fy}) * py;
			zd_q[0] <= zero_s1;
			for (int i = 1; i < DL; i++) zd_q[i] <= zd_q[i-1];
			x_s3 <= xq;
			y_s3 <= yq;
		end
	end

	assign xn = {px_s1, 24'b0};
	assign yn = {py_s1, 24'b0};

	pinrd_div #(.DW(57), .VW(32), .QW(NQW)) u_div_u (
		.clk(clk), .en(en), .num(pu_s1), .den(pz_s1), .quo(du), .ovf(ovf_u));
	pinrd_div #(.DW(57), .VW(32), .QW(NQW)) u_div_v (
		.clk(clk), .en(en), .num(pv_s1), .den(pz_s1), .quo(dv), .ovf(ovf_v));
	pinrd_div #(.DW(56), .VW(32), .QW(NQW)) u_div_x (
		.clk(clk), .en(en), .num(xn), .den(pz_s1), .quo(xq), .ovf(ovf_x));
	pinrd_div #(.DW(56), .VW(32), .QW(NQW)) u_div_y (
		.clk(clk), .en(en), .num(yn), .den(pz_s1), .quo(yq), .ovf(ovf_y));

	always_comb begin
		u = 29'(du) + $signed({5'b0, cx});
		v = 29'(dv) + $signed({5'b0, cy});
		view = !zd_q[DL-1] && !ovf_u && !ovf_v && !u[28] && !v[28]
			&& (u <= U_MAX) && (v <= V_MAX);
	end

	assign ctl_out = ctl_s3;
	assign nx = x_s3;
	assign ny = y_s3;

	// clamped normalized coordinates need no overflow flag
	logic unused_ovf;
	assign unused_ovf = ovf_x ^ ovf_y;
endmodule

// ----- design/pinrd_dist.sv -----
// Distortion back end: radial powers, rational factor, tangential terms, pixel scaling
module pinrd_dist (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  pinrd_pkg::ctl_t     ctl_in,
	input  logic signed [26:0]  x,
	input  logic signed [26:0]  y,
	input  pinrd_pkg::coef_t    coef,
	input  logic [23:0]         fx,
	input  logic [23:0]         fy,
	input  logic [23:0]         cx,
	input  logic [23:0]         cy,
	output pinrd_pkg::ctl_t     ctl_out,
	output logic signed [23:0]  pu,
	output logic signed [23:0]  pv
);
	import pinrd_pkg::*;

	localparam int DL = QQW + 1;
	localparam logic signed [47:0] QMAX = 48'sd34359738367;
	localparam logic signed [47:0] QMIN = -48'sd34359738367;
	localparam logic signed [47:0] ONE = 48'sd16777216;
	localparam logic signed [41:0] PMAX = 42'sd8388607;
	localparam logic signed [41:0] PMIN = -42'sd8388608;

	logic signed [23:0] k1, k2, k3, k4, k5, k6, p1, p2;
	ctl_t c_s1, c_s2, c_s3, c_s4, c_s5, c_s6, c_s7, c_s8, c_s9, c_s10, c_s11, c_s12;
	ctl_t cd_q [0:DL-1];
	logic signed [26:0] x_s1, y_s1, x_s2, y_s2, x_s3, y_s3, x_s4, y_s4;
	logic signed [26:0] x_s5, y_s5, x_s6, y_s6, x_s7, y_s7, x_s8, y_s8;
	logic signed [26:0] xd_q [0:DL-1];
	logic signed [26:0] yd_q [0:DL-1];
	logic signed [53:0] xx_s1, yy_s1, xy_s1;
	logic signed [29:0] xx_s2, yy_s2, xy_s2;
	logic signed [30:0] r2_s2, r2_s3, r2_s4;
	logic signed [61:0] r4p_s3;
	logic signed [54:0] a1_s3, a4_s3;
	logic signed [53:0] tp1_s3, tq2_s3;
	logic signed [55:0] tp2_s3, tq1_s3;
	logic signed [31:0] sx, sy;
	logic signed [35:0] r4_s4, r4_s5;
	logic signed [35:0] tk1_s4, tk4_s4, tk1_s5, tk4_s5, tk1_s6, tk4_s6, tk1_s7, tk4_s7;
	logic signed [56:0] tsx, tsy;
	logic signed [36:0] tx_s4, ty_s4, tx_s5, ty_s5, tx_s6, ty_s6, tx_s7, ty_s7;
	logic signed [36:0] tx_s8, ty_s8;
	logic signed [36:0] txd_q [0:DL-1];
	logic signed [36:0] tyd_q [0:DL-1];
	logic signed [66:0] r6p_s5;
	logic signed [59:0] b2_s5, b5_s5;
	logic signed [40:0] r6_s6;
	logic signed [39:0] tk2_s6, tk5_s6, tk2_s7, tk5_s7;
	logic signed [64:0] c3_s7, c6_s7;
	logic signed [47:0] nsum, dsum;
	logic signed [35:0] num_s8, den_s8;
	logic signed [59:0] nshift;
	logic signed [QQW:0] q;
	logic               q_ovf;
	logic signed [62:0] xq_s9, yq_s9;
	logic signed [36:0] tx_s9, ty_s9;
	logic signed [39:0] xd_s10, yd_s10;
	logic signed [64:0] pu_s11, pv_s11;
	logic signed [41:0] wu, wv;
	logic signed [23:0] pu_s12, pv_s12;

	always_comb begin
		k1 = coef.k1;
		k2 = coef.k2;
		k3 = coef.k3;
		k4 = coef.k4;
		k5 = coef.k5;
		k6 = coef.k6;
		p1 = coef.p1;
		p2 = coef.p2;
		sx = 32'(r2_s2) + 32'(xx_s2) + 32'(xx_s2);
		sy = 32'(r2_s2) + 32'(yy_s2) + 32'(yy_s2);
		tsx = 57'(tp1_s3) + 57'(tp1_s3) + 57'(tp2_s3);
		tsy = 57'(tq1_s3) + 57'(tq2_s3) + 57'(tq2_s3);
		nsum = ONE + 48'(tk1_s7) + 48'(tk2_s7) + 48'((c3_s7 + 65'sd524288) >>> 20);
		dsum = ONE + 48'(tk4_s7) + 48'(tk5_s7) + 48'((c6_s7 + 65'sd524288) >>> 20);
		nshift = {num_s8, 24'b0};
		wu = 42'((pu_s11 + 65'sd8388608) >>> 24) + $signed({18'b0, cx});
		wv = 42'((pv_s11 + 65'sd8388608) >>> 24) + $signed({18'b0, cy});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s1 <= '0; c_s2 <= '0; c_s3 <= '0; c_s4 <= '0;
			c_s5 <= '0; c_s6 <= '0; c_s7 <= '0; c_s8 <= '0;
			c_s9 <= '0; c_s10 <= '0; c_s11 <= '0; c_s12 <= '0;
			for (int i = 0; i < DL; i++) cd_q[i] <= '0;
		end else if (en) begin
			c_s1 <= ctl_in; c_s2 <= c_s1; c_s3 <= c_s2; c_s4 <= c_s3;
			c_s5 <= c_s4; c_s6 <= c_s5; c_s7 <= c_s6; c_s8 <= c_s7;
			cd_q[0] <= c_s8;
			for (int i = 1; i < DL; i++) cd_q[i] <= cd_q[i-1];
			c_s9 <= cd_q[DL-1]; c_s10 <= c_s9; c_s11 <= c_s10; c_s12 <= c_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x; y_s1 <= y;
			xx_s1 <= x * x;
			yy_s1 <= y * y;
			xy_s1 <= x * y;

			x_s2 <= x_s1; y_s2 <= y_s1;
			xx_s2 <= 30'((xx_s1 + 54'sd8388608) >>> 24);
			yy_s2 <= 30'((yy_s1 + 54'sd8388608) >>> 24);
			xy_s2 <= 30'((xy_s1 + 54'sd8388608) >>> 24);
			r2_s2 <= 31'((55'(xx_s1) + 55'(yy_s1) + 55'sd8388608) >>> 24);

			x_s3 <= x_s2; y_s3 <= y_s2; r2_s3 <= r2_s2;
			r4p_s3 <= r2_s2 * r2_s2;
			a1_s3 <= k1 * r2_s2;
			a4_s3 <= k4 * r2_s2;
			tp1_s3 <= p1 * xy_s2;
			tp2_s3 <= p2 * sx;
			tq1_s3 <= p1 * sy;
			tq2_s3 <= p2 * xy_s2;

			x_s4 <= x_s3; y_s4 <= y_s3; r2_s4 <= r2_s3;
			r4_s4 <= 36'((r4p_s3 + 62'sd8388608) >>> 24);
			tk1_s4 <= 36'((a1_s3 + 55'sd524288) >>> 20);
			tk4_s4 <= 36'((a4_s3 + 55'sd524288) >>> 20);
			tx_s4 <= 37'((tsx + 57'sd524288) >>> 20);
			ty_s4 <= 37'((tsy + 57'sd524288) >>> 20);

			x_s5 <= x_s4; y_s5 <= y_s4; r4_s5 <= r4_s4;
			tk1_s5 <= tk1_s4; tk4_s5 <= tk4_s4; tx_s5 <= tx_s4; ty_s5 <= ty_s4;
			r6p_s5 <= r4_s4 * r2_s4;
			b2_s5 <= k2 * r4_s4;
			b5_s5 <= k5 * r4_s4;

			x_s6 <= x_s5; y_s6 <= y_s5;
			tk1_s6 <= tk1_s5; tk4_s6 <= tk4_s5; tx_s6 <= tx_s5; ty_s6 <= ty_s5;
			r6_s6 <= 41'((r6p_s5 + 67'sd8388608) >>> 24);
			tk2_s6 <= 40'((b2_s5 + 60'sd524288) >>> 20);
			tk5_s6 <= 40'((b5_s5 + 60'sd524288) >>> 20);

			x_s7 <= x_s6; y_s7 <= y_s6;
			tk1_s7 <= tk1_s6; tk4_s7 <= tk4_s6; tx_s7 <= tx_s6; ty_s7 <= ty_s6;
			tk2_s7 <= tk2_s6; tk5_s7 <= tk5_s6;
			c3_s7 <= k3 * r6_s6;
			c6_s7 <= k6 * r6_s6;

			x_s8 <= x_s7; y_s8 <= y_s7; tx_s8 <= tx_s7; ty_s8 <= ty_s7;
			num_s8 <= (nsum > QMAX) ? 36'(QMAX) : ((nsum < QMIN) ? 36'(QMIN) : 36'(nsum));
			den_s8 <= (dsum > QMAX) ? 36'(QMAX) : ((dsum < QMIN) ? 36'(QMIN) : 36'(dsum));

			xd_q[0] <= x_s8; yd_q[0] <= y_s8; txd_q[0] <= tx_s8; tyd_q[0] <= ty_s8;
			for (int i = 1; i < DL; i++) begin
				xd_q[i] <= xd_q[i-1];
				yd_q[i] <= yd_q[i-1];
				txd_q[i] <= txd_q[i-1];
				tyd_q[i] <= tyd_q[i-1];
			end

			xq_s9 <= xd_q[DL-1] * q;
			yq_s9 <= yd_q[DL-1] * q;
			tx_s9 <= txd_q[DL-1];
			ty_s9 <= tyd_q[DL-1];

			xd_s10 <= 40'((xq_s9 + 63'sd8388608) >>> 24) + 40'(tx_s9);
			yd_s10 <= 40'((yq_s9 + 63'sd8388608) >>> 24) + 40'(ty_s9);

			pu_s11 <= xd_s10 * $signed({1'b0, fx});
			pv_s11 <= yd_s10 * $signed({1'b0, fy});

			if (!c_s11.view) begin
				pu_s12 <= PIX_OFF;
				pv_s12 <= PIX_OFF;
			end else begin
				pu_s12 <= (wu > PMAX) ? 24'(PMAX) : ((wu < PMIN) ? 24'(PMIN) : 24'(wu));
				pv_s12 <= (wv > PMAX) ? 24'(PMAX) : ((wv < PMIN) ? 24'(PMIN) : 24'(wv));
			end
		end
	end

	pinrd_div #(.DW(60), .VW(36), .QW(QQW)) u_div_q (
		.clk(clk), .en(en), .num(nshift), .den(den_s8), .quo(q), .ovf(q_ovf));

	// the clamped quotient already carries saturation
	logic unused_q_ovf;
	assign unused_q_ovf = q_ovf;

	assign ctl_out = c_s12;
	assign pu = pu_s12;
	assign pv = pv_s12;
endmodule

// ----- bench/tb_pinhole_rational_distortion_project.sv -----
// Self-checking bench for the pinhole projection block with rational lens distortion
`timescale 1ns / 1ps

import pinrd_pkg::*;

typedef struct {
	bit          view;
	logic [23:0] u;
	logic [23:0] v;
} pixel_item_t;

class pixel_scoreboard;
	logic [47:0] regs [8];
	pixel_item_t pending [$];
	int          errs;

	function new();
		reset_regs();
		errs = 0;
	endfunction

	function void reset_regs();
		foreach (regs[i])
			regs[i] = '0;
		regs[REG_FOCAL_X] = 48'd256;
		regs[REG_FOCAL_Y] = 48'd256;
	endfunction

	function void set_reg(logic [CFG_IW-1:0] idx, logic [47:0] data);
		if (idx < 4)
			regs[idx] = {24'd0, data[23:0]};
		else if (idx < 8)
			regs[idx] = data;
	endfunction

	static function longint rnd(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	static function longint clip(longint v, longint lim_lo, longint lim_hi);
		return v < lim_lo ? lim_lo : (v > lim_hi ? lim_hi : v);
	endfunction

	static function longint coef(logic [23:0] c);
		logic signed [23:0] s;
		s = c;
		return longint'(s);
	endfunction

	function void note_point(logic signed [31:0] px_in, py_in, pz_in);
		longint px, py, pz, fx, fy, cx, cy, u, v, x, y, xx, yy, xy, r2, r4, r6;
		longint num, den, q, tx, ty, xd, yd, pu, pv, nmax, qmax;
		longint k1, k2, k3, k4, k5, k6, p1, p2;
		pixel_item_t e;
		px = px_in;
		py = py_in;
		pz = pz_in;
		fx = regs[REG_FOCAL_X][23:0];
		fy = regs[REG_FOCAL_Y][23:0];
		cx = regs[REG_CENTER_X][23:0];
		cy = regs[REG_CENTER_Y][23:0];
		k1 = coef(regs[REG_K1_K2][47:24]);
		k2 = coef(regs[REG_K1_K2][23:0]);
		p1 = coef(regs[REG_P1_P2][47:24]);
		p2 = coef(regs[REG_P1_P2][23:0]);
		k3 = coef(regs[REG_K3_K4][47:24]);
		k4 = coef(regs[REG_K3_K4][23:0]);
		k5 = coef(regs[REG_K5_K6][47:24]);
		k6 = coef(regs[REG_K5_K6][23:0]);
		nmax = (longint'(1) <<< 26) - 1;
		qmax = (longint'(1) <<< 35) - 1;
		e.view = (pz != 0);
		if (e.view) begin
			u = (fx * px) / pz + cx;
			v = (fy * py) / pz + cy;
			if (u < 0 || u > 1024 * 256 || v < 0 || v > 1024 * 256)
				e.view = 0;
		end
		if (!e.view) begin
			e.u = PIX_OFF;
			e.v = PIX_OFF;
		end else begin
			x = clip((px <<< 24) / pz, -nmax, nmax);
			y = clip((py <<< 24) / pz, -nmax, nmax);
			xx = rnd(x * x, 24);
			yy = rnd(y * y, 24);
			xy = rnd(x * y, 24);
			r2 = rnd(x * x + y * y, 24);
			r4 = rnd(r2 * r2, 24);
			r6 = rnd(r4 * r2, 24);
			num = (longint'(1) <<< 24) + rnd(k1 * r2, 20) + rnd(k2 * r4, 20) + rnd(k3 * r6, 20);
			den = (longint'(1) <<< 24) + rnd(k4 * r2, 20) + rnd(k5 * r4, 20) + rnd(k6 * r6, 20);
			num = clip(num, -qmax, qmax);
			den = clip(den, -qmax, qmax);
			if (den == 0)
				q = (num >= 0) ? qmax : -qmax;
			else
				q = clip((num <<< 24) / den, -qmax, qmax);
			tx = rnd(2 * p1 * xy + p2 * (r2 + 2 * xx), 20);
			ty = rnd(p1 * (r2 + 2 * yy) + 2 * p2 * xy, 20);
			xd = rnd(x * q, 24) + tx;
			yd = rnd(y * q, 24) + ty;
			pu = clip(rnd(xd * fx, 24) + cx, -(longint'(1) <<< 23), (longint'(1) <<< 23) - 1);
			pv = clip(rnd(yd * fy, 24) + cy, -(longint'(1) <<< 23), (longint'(1) <<< 23) - 1);
			e.u = pu[23:0];
			e.v = pv[23:0];
		end
		pending.push_back(e);
	endfunction

	function void check_pixel(logic view, logic [23:0] u, logic [23:0] v);
		pixel_item_t e;
		if (pending.size() == 0) begin
			errs++;
			if (errs <= 10)
				$display("unexpected pixel: view=%0b u=%0d v=%0d", view, $signed(u), $signed(v));
			return;
		end
		e = pending.pop_front();
		if (view !== e.view || u !== e.u || v !== e.v) begin
			errs++;
			if (errs <= 10)
				$display("pixel mismatch: exp view=%0b u=%0d v=%0d, got view=%0b u=%0d v=%0d",
					e.view, $signed(e.u), $signed(e.v), view, $signed(u), $signed(v));
		end
	endfunction
endclass

module tb_pinhole_rational_distortion_project;
	localparam logic [CFG_IW-1:0] IDX_UNUSED = 4'd12;
	localparam int LIMIT = 600000;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              cfg_valid = 0;
	logic              cfg_ready;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [47:0]       cfg_data = '0;
	logic              point_valid = 0;
	logic              point_stall;
	logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
	logic              pixel_valid;
	logic              pixel_stall = 0;
	logic              in_view;
	logic signed [23:0] pixel_u, pixel_v;

	pixel_scoreboard sb = new();
	int  send_idle = 0;
	int  stall_pct = 0;
	logic hold_on = 0;
	logic hold_go = 0;
	int  cycles = 0;

	pinhole_rational_distortion_project dut (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_pinhole_rational_distortion_project NOT OK");
			$finish;
		end
	end

	always @(posedge clk)
		pixel_stall <= hold_on || ($urandom_range(99) < stall_pct);

	initial begin
		wait (hold_go);
		hold_on <= 1;
		repeat (400) @(posedge clk);
		hold_on <= 0;
	end

	always @(posedge clk) begin
		if (arst_n && point_valid && !point_stall)
			sb.note_point(point_x, point_y, point_z);
		if (arst_n && pixel_valid && !pixel_stall)
			sb.check_pixel(in_view, pixel_u, pixel_v);
	end

	task automatic send_point(logic signed [31:0] x, y, z);
		while ($urandom_range(99) < send_idle) begin
			point_valid <= 0;
			@(posedge clk);
		end
		point_valid <= 1;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		do
			@(posedge clk);
		while (point_stall);
	endtask

	task automatic drain();
		point_valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (90) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [47:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_reg(idx, data);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic load_camera(logic [23:0] fx, fy, cx, cy, logic [47:0] k12, p12, k34, k56);
		write_reg(REG_FOCAL_X, {24'd0, fx});
		write_reg(REG_FOCAL_Y, {24'd0, fy});
		write_reg(REG_CENTER_X, {24'd0, cx});
		write_reg(REG_CENTER_Y, {24'd0, cy});
		write_reg(REG_K1_K2, k12);
		write_reg(REG_P1_P2, p12);
		write_reg(REG_K3_K4, k34);
		write_reg(REG_K5_K6, k56);
	endtask

	function automatic logic [47:0] rand_pair(int span);
		logic [23:0] a, b;
		a = $urandom_range(2 * span) - span;
		b = $urandom_range(2 * span) - span;
		return {a, b};
	endfunction

	function automatic logic signed [31:0] aim(longint target, longint c, longint f, longint z);
		longint t;
		t = (target - c) * z / f;
		if (t > 64'sd2147483647)
			t = 64'sd2147483647;
		if (t < -64'sd2147483648)
			t = -64'sd2147483648;
		return t[31:0];
	endfunction

	task automatic random_point();
		longint z;
		int sel;
		sel = $urandom_range(99);
		if (sel < 12) begin
			send_point($urandom, $urandom, $urandom);
		end else begin
			z = $urandom_range(1 << 22, 1 << 16);
			if (sel < 22)
				z = -z;
			if (sel < 25)
				z = longint'($urandom_range(3)) - 1;
			send_point(
				aim(longint'($urandom_range(1100 * 256)) - 30 * 256,
					sb.regs[REG_CENTER_X][23:0], sb.regs[REG_FOCAL_X][23:0], z),
				aim(longint'($urandom_range(1100 * 256)) - 30 * 256,
					sb.regs[REG_CENTER_Y][23:0], sb.regs[REG_FOCAL_Y][23:0], z),
				z[31:0]);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_point(32'sd0, 32'sd0, 32'sd0);
		send_point(32'sd65536, 32'sd65536, 32'sd0);
		send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_point(32'sh7fffffff, 32'sh80000000, 32'sd1);
		send_point(32'sd0, 32'sd0, 32'sh7fffffff);
		send_point(-32'sd65536, -32'sd65536, -32'sd65536);
		send_point(32'sd65536, 32'sd131072, 32'sd65536);
		drain();

		write_reg(IDX_UNUSED, 48'hffff_ffff_ffff);
		load_camera(24'd51200, 24'd51200, 24'd131072, 24'd131072,
			48'd0, 48'd0, {24'd0, -24'sd1048576}, 48'd0);
		send_point(32'sd65536, 32'sd0, 32'sd65536);
		send_point(-32'sd65536, 32'sd0, 32'sd65536);
		send_point(32'sd65536, 32'sd0, -32'sd65536);
		send_point(32'sd0, 32'sd0, 32'sd65536);
		send_point(32'sd0, 32'sd200000, 32'sd65536);
		drain();

		load_camera(24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff,
			48'h7fffff_7fffff, 48'h7fffff_7fffff, 48'h7fffff_7fffff, 48'h7fffff_7fffff);
		send_point(32'sd0, 32'sd0, 32'sd65536);
		send_point(-32'sd1, -32'sd1, 32'sd65536);
		send_point(-32'sd30000, -32'sd30000, 32'sd65536);
		drain();

		load_camera(24'd1, 24'd1, 24'd0, 24'd0,
			48'h800000_800000, 48'h800000_800000, 48'h800000_800000, 48'h800000_800000);
		send_point(32'sd0, 32'sd0, 32'sd65536);
		send_point(32'sh7fffffff, 32'sh7fffffff, 32'sd1);
		send_point(32'sh7fffffff, 32'sh7fffffff, -32'sd1);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0;  stall_pct = 0;  end
				1: begin send_idle = 71; stall_pct = 0;  end
				2: begin send_idle = 0;  stall_pct = 71; end
				default: begin send_idle = 35; stall_pct = 35; end
			endcase
			if (ph == 7)
				load_camera(24'hffffff, 24'd1, 24'd0, 24'hffffff,
					rand_pair(1 << 23), rand_pair(1 << 23), rand_pair(1 << 23),
					rand_pair(1 << 23));
			else
				load_camera($urandom_range(300000, 20000), $urandom_range(300000, 20000),
					$urandom_range(262144), $urandom_range(262144),
					rand_pair(1 << 18), rand_pair(1 << 12), rand_pair(1 << 14),
					rand_pair(1 << 14));
			for (int n = 0; n < 205; n++) begin
				if (ph == 2 && n == 40)
					hold_go <= 1;
				if (ph == 4 && n == 100) begin
					point_valid <= 0;
					while (sb.pending.size() != 0)
						@(posedge clk);
				end
				random_point();
			end
			drain();
		end

		if (sb.errs == 0 && sb.pending.size() == 0)
			$display("tb_pinhole_rational_distortion_project OK");
		else
			$display("tb_pinhole_rational_distortion_project NOT OK");
		$finish;
	end
endmodule
